// File: hdl/cht_pkg.sv
package cht_pkg;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic {
      OP_SEARCH = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RUN  = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   // control part of the token that walks the cell row
   typedef struct packed {
      logic   valid;
      op_type op;
      logic   done;
      logic   was_new;
   } tok_ctl_type;

endpackage

// File: hdl/colour_histogram_table.sv
// Pixels and in-range reads walk the row of TABLE_DEPTH cells, one cell per cycle,
// and the result is registered when the token leaves the last cell.
// Clears, out-of-range reads, no-ops and pixels while failed skip the row.
// One request at a time, taken the cycle after the previous result loads the output
// register; a stalled result holds back the next.
// Sync reset empties the table, clears failure, max_unique=DEPTH.
module colour_histogram_table #(
   parameter int TABLE_DEPTH = 256,
   parameter int COUNT_BITS  = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_kind,
   input  logic [31:0]                            req_argb,
   input  logic                                   req_row_start,
   input  logic [$clog2(TABLE_DEPTH)-1:0]         req_read_index,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_status,
   output logic                                   rsp_was_new,
   output logic [$clog2(TABLE_DEPTH)-1:0]         rsp_entry_index,
   output logic [31:0]                            rsp_entry_colour,
   output logic [COUNT_BITS-1:0]                  rsp_entry_count,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]       rsp_entries_used,
   input  logic                                   csr_wen,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]       csr_wdata
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int USED_W = $clog2(TABLE_DEPTH+1);

   cht_pkg::state_type    state_ff, state_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic                  failed_ff, failed_in;
   logic [USED_W-1:0]     max_unique_ff;

   logic                  res_status_ff, res_status_in;
   logic                  res_new_ff, res_new_in;
   logic [IDX_W-1:0]      res_idx_ff, res_idx_in;
   logic [31:0]           res_colour_ff, res_colour_in;
   logic [COUNT_BITS-1:0] res_count_ff, res_count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic                  rsp_was_new_ff, rsp_was_new_in;
   logic [IDX_W-1:0]      rsp_entry_index_ff, rsp_entry_index_in;
   logic [31:0]           rsp_entry_colour_ff, rsp_entry_colour_in;
   logic [COUNT_BITS-1:0] rsp_entry_count_ff, rsp_entry_count_in;
   logic [USED_W-1:0]     rsp_entries_used_ff, rsp_entries_used_in;

   cht_pkg::tok_ctl_type  ctl_w    [TABLE_DEPTH+1];
   logic [31:0]           colour_w [TABLE_DEPTH+1];
   logic [USED_W-1:0]     target_w [TABLE_DEPTH+1];
   logic [IDX_W-1:0]      idx_w    [TABLE_DEPTH+1];
   logic [COUNT_BITS-1:0] count_w  [TABLE_DEPTH+1];

   cht_pkg::kind_type     kind;
   logic                  accept, row_fail, rd_ok;
   cht_pkg::tok_ctl_type  tail;
   cht_pkg::tok_ctl_type  head_ctl;
   logic [USED_W-1:0]     head_target;

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
         cht_cell #(
            .IDX_W      (IDX_W),
            .USED_W     (USED_W),
            .COUNT_BITS (COUNT_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_idx   (IDX_W'(gi)),
            .ctl_in     (ctl_w[gi]),
            .colour_in  (colour_w[gi]),
            .target_in  (target_w[gi]),
            .idx_in     (idx_w[gi]),
            .count_in   (count_w[gi]),
            .ctl_out    (ctl_w[gi+1]),
            .colour_out (colour_w[gi+1]),
            .target_out (target_w[gi+1]),
            .idx_out    (idx_w[gi+1]),
            .count_out  (count_w[gi+1])
         );
      end
   endgenerate

   assign ctl_w[0]    = head_ctl;
   assign colour_w[0] = req_argb;
   assign target_w[0] = head_target;
   assign idx_w[0]    = '0;
   assign count_w[0]  = '0;

   assign tail      = ctl_w[TABLE_DEPTH];
   assign req_stall = (state_ff != cht_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign kind      = cht_pkg::kind_type'(req_kind);
   assign row_fail  = req_row_start && (used_ff > max_unique_ff);
   assign rd_ok     = USED_W'(req_read_index) < used_ff;

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      failed_in     = failed_ff;
      res_status_in = res_status_ff;
      res_new_in    = res_new_ff;
      res_idx_in    = res_idx_ff;
      res_colour_in = res_colour_ff;
      res_count_in  = res_count_ff;

      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_status_in       = rsp_status_ff;
      rsp_was_new_in      = rsp_was_new_ff;
      rsp_entry_index_in  = rsp_entry_index_ff;
      rsp_entry_colour_in = rsp_entry_colour_ff;
      rsp_entry_count_in  = rsp_entry_count_ff;
      rsp_entries_used_in = rsp_entries_used_ff;

      head_ctl    = '0;
      head_target = used_ff;

      unique case (state_ff)
         cht_pkg::ST_IDLE: begin
            if (accept) begin
               state_in      = cht_pkg::ST_DONE;
               res_status_in = failed_ff;
               res_new_in    = 1'b0;
               res_idx_in    = '0;
               res_colour_in = '0;
               res_count_in  = '0;
               unique case (kind)
                  cht_pkg::KIND_PIXEL: begin
                     if (failed_ff || row_fail) begin
                        failed_in     = 1'b1;
                        res_status_in = 1'b1;
                     end else begin
                        head_ctl.valid = 1'b1;
                        head_ctl.op    = cht_pkg::OP_SEARCH;
                        state_in       = cht_pkg::ST_RUN;
                     end
                  end
                  cht_pkg::KIND_READ: begin
                     res_idx_in = req_read_index;
                     if (rd_ok) begin
                        head_ctl.valid = 1'b1;
                        head_ctl.op    = cht_pkg::OP_READ;
                        head_target    = USED_W'(req_read_index);
                        state_in       = cht_pkg::ST_RUN;
                     end
                  end
                  cht_pkg::KIND_CLEAR: begin
                     used_in       = '0;
                     failed_in     = 1'b0;
                     res_status_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         cht_pkg::ST_RUN: begin
            if (tail.valid) begin
               state_in      = cht_pkg::ST_DONE;
               // a search that found neither a match nor a free cell: table full;
               // a read reports the failure flag
               res_status_in = failed_ff || !tail.done;
               res_new_in    = tail.done && tail.was_new;
               res_idx_in    = tail.done ? idx_w[TABLE_DEPTH] : '0;
               res_colour_in = tail.done ? colour_w[TABLE_DEPTH] : '0;
               res_count_in  = tail.done ? count_w[TABLE_DEPTH] : '0;
               if (tail.done && tail.was_new) begin
                  used_in = used_ff + USED_W'(1);
               end
               if (!tail.done) begin
                  failed_in = 1'b1;
               end
            end
         end
         cht_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in            = cht_pkg::ST_IDLE;
               rsp_valid_in        = 1'b1;
               rsp_status_in       = res_status_ff;
               rsp_was_new_in      = res_new_ff;
               rsp_entry_index_in  = res_idx_ff;
               rsp_entry_colour_in = res_colour_ff;
               rsp_entry_count_in  = res_count_ff;
               rsp_entries_used_in = used_ff;
            end
         end
         default: begin
            state_in = cht_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cht_pkg::ST_IDLE;
         used_ff       <= '0;
         failed_ff     <= 1'b0;
         max_unique_ff <= USED_W'(TABLE_DEPTH);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            max_unique_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff       <= res_status_in;
      res_new_ff          <= res_new_in;
      res_idx_ff          <= res_idx_in;
      res_colour_ff       <= res_colour_in;
      res_count_ff        <= res_count_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_was_new_ff      <= rsp_was_new_in;
      rsp_entry_index_ff  <= rsp_entry_index_in;
      rsp_entry_colour_ff <= rsp_entry_colour_in;
      rsp_entry_count_ff  <= rsp_entry_count_in;
      rsp_entries_used_ff <= rsp_entries_used_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_was_new      = rsp_was_new_ff;
   assign rsp_entry_index  = rsp_entry_index_ff;
   assign rsp_entry_colour = rsp_entry_colour_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;
   assign rsp_entries_used = rsp_entries_used_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_tail_in_run: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> state_ff == cht_pkg::ST_RUN)
      else $error("token left the cell row outside a search");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != cht_pkg::ST_IDLE)
      else $error("accepted request did not start work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == cht_pkg::ST_DONE)
      else $error("response raised without a finished request");
`endif

endmodule

// File: hdl/cht_cell.sv
module cht_cell #(
   parameter int IDX_W      = 8,
   parameter int USED_W     = 9,
   parameter int COUNT_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [IDX_W-1:0]         cell_idx,
   input  cht_pkg::tok_ctl_type     ctl_in,
   input  logic [31:0]              colour_in,
   input  logic [USED_W-1:0]        target_in,
   input  logic [IDX_W-1:0]         idx_in,
   input  logic [COUNT_BITS-1:0]    count_in,
   output cht_pkg::tok_ctl_type     ctl_out,
   output logic [31:0]              colour_out,
   output logic [USED_W-1:0]        target_out,
   output logic [IDX_W-1:0]         idx_out,
   output logic [COUNT_BITS-1:0]    count_out
);

   logic [31:0]           colour_ff;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   cht_pkg::tok_ctl_type  tctl_ff, tctl_in;
   logic [31:0]           tcolour_ff, tcolour_in;
   logic [USED_W-1:0]     target_ff;
   logic [IDX_W-1:0]      tidx_ff, tidx_in;
   logic [COUNT_BITS-1:0] tcount_ff, tcount_in;

   logic                  live, below, here, match, append, rd;
   logic [USED_W-1:0]     idx_ext;
   logic [COUNT_BITS-1:0] count_inc;

   always_comb begin
      idx_ext   = USED_W'(cell_idx);
      live      = ctl_in.valid && !ctl_in.done;
      below     = idx_ext < target_in;
      here      = idx_ext == target_in;
      match     = live && (ctl_in.op == cht_pkg::OP_SEARCH) && below
                  && (colour_ff == colour_in);
      append    = live && (ctl_in.op == cht_pkg::OP_SEARCH) && here;
      rd        = live && (ctl_in.op == cht_pkg::OP_READ) && here;
      // saturate at all ones
      count_inc = (&cnt_ff) ? cnt_ff : cnt_ff + COUNT_BITS'(1);

      cnt_in = cnt_ff;
      if (match) begin
         cnt_in = count_inc;
      end else if (append) begin
         cnt_in = COUNT_BITS'(1);
      end

      tctl_in         = ctl_in;
      tctl_in.done    = ctl_in.done || match || append || rd;
      tctl_in.was_new = ctl_in.was_new || append;
      tcolour_in      = rd ? colour_ff : colour_in;
      tidx_in         = (match || append || rd) ? cell_idx : idx_in;
      tcount_in       = count_in;
      if (match) begin
         tcount_in = count_inc;
      end else if (append) begin
         tcount_in = COUNT_BITS'(1);
      end else if (rd) begin
         tcount_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (append) begin
         colour_ff <= colour_in;
      end
      cnt_ff     <= cnt_in;
      tcolour_ff <= tcolour_in;
      target_ff  <= target_in;
      tidx_ff    <= tidx_in;
      tcount_ff  <= tcount_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tctl_ff <= '0;
      end else begin
         tctl_ff <= tctl_in;
      end
   end

   assign ctl_out    = tctl_ff;
   assign colour_out = tcolour_ff;
   assign target_out = target_ff;
   assign idx_out    = tidx_ff;
   assign count_out  = tcount_ff;

endmodule

// File: tb/colour_histogram_table_tb.sv
module colour_histogram_table_tb;

   localparam int DEPTH       = 256;
   localparam int CNT_W       = 24;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int USED_W      = $clog2(DEPTH + 1);
   localparam int STUCK_LIMIT = 8 * (DEPTH + 2) + 500;
   localparam int PALETTE_N   = 10;
   localparam int N_PHASES    = 8;

   typedef struct packed {
      logic              status;
      logic              was_new;
      logic [IDX_W-1:0]  index;
      logic [31:0]       colour;
      logic [CNT_W-1:0]  count;
      logic [USED_W-1:0] used;
   } lookup_type;

   typedef struct {
      bit                cfg_en;
      logic [USED_W-1:0] cfg_val;
      cht_pkg::kind_type kind;
      logic [31:0]       argb;
      logic              row_start;
      logic [IDX_W-1:0]  rd_idx;
      bit                typed;
      lookup_type        res;
   } step_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_kind;
   logic [31:0]       req_argb;
   logic              req_row_start;
   logic [IDX_W-1:0]  req_read_index;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_status;
   logic              rsp_was_new;
   logic [IDX_W-1:0]  rsp_entry_index;
   logic [31:0]       rsp_entry_colour;
   logic [CNT_W-1:0]  rsp_entry_count;
   logic [USED_W-1:0] rsp_entries_used;
   logic              csr_wen;
   logic [USED_W-1:0] csr_wdata;

   // predictor copy of the table
   logic [31:0]      colour_mem [DEPTH];
   logic [CNT_W-1:0] count_mem [DEPTH];
   int unsigned      used_n = 0;
   logic             failed = 1'b0;
   int unsigned      max_unique_cfg = DEPTH;

   lookup_type  pending_results[$];
   step_type    directed_steps[$];
   bit          typed_valid = 1'b0;
   lookup_type  typed_result = '0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned result_count = 0;
   int unsigned sent_count = 0;
   int unsigned stuck_cycles = 0;
   logic [31:0] palette [PALETTE_N];

   colour_histogram_table #(
      .TABLE_DEPTH(DEPTH),
      .COUNT_BITS (CNT_W)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_argb        (req_argb),
      .req_row_start   (req_row_start),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_was_new     (rsp_was_new),
      .rsp_entry_index (rsp_entry_index),
      .rsp_entry_colour(rsp_entry_colour),
      .rsp_entry_count (rsp_entry_count),
      .rsp_entries_used(rsp_entries_used),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic lookup_type predict_histogram(cht_pkg::kind_type kind,
                                                    logic [31:0] argb, logic row_start,
                                                    logic [IDX_W-1:0] rd_idx);
      lookup_type r;
      int         hit;
      r   = '0;
      hit = -1;
      case (kind)
         cht_pkg::KIND_PIXEL: begin
            if (row_start && used_n > max_unique_cfg)
               failed = 1'b1;
            if (failed) begin
               r.status = 1'b1;
            end else begin
               for (int i = 0; i < int'(used_n); i++)
                  if (hit < 0 && colour_mem[i] == argb)
                     hit = i;
               if (hit >= 0) begin
                  if (count_mem[hit] != '1)
                     count_mem[hit] = count_mem[hit] + CNT_W'(1);
                  r.index  = IDX_W'(hit);
                  r.colour = argb;
                  r.count  = count_mem[hit];
               end else if (used_n >= DEPTH) begin
                  // new colour with no free entry
                  failed   = 1'b1;
                  r.status = 1'b1;
               end else begin
                  colour_mem[used_n] = argb;
                  count_mem[used_n]  = CNT_W'(1);
                  r.was_new = 1'b1;
                  r.index   = IDX_W'(used_n);
                  r.colour  = argb;
                  r.count   = CNT_W'(1);
                  used_n++;
               end
            end
         end
         cht_pkg::KIND_READ: begin
            r.status = failed;
            r.index  = rd_idx;
            if (rd_idx < used_n) begin
               r.colour = colour_mem[rd_idx];
               r.count  = count_mem[rd_idx];
            end
         end
         cht_pkg::KIND_CLEAR: begin
            used_n = 0;
            failed = 1'b0;
         end
         default: r.status = failed;
      endcase
      r.used = USED_W'(used_n);
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (expv !== actv) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      lookup_type expd;
      if (!reset) begin
         if (csr_wen)
            max_unique_cfg = 32'(csr_wdata);
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               expd = pending_results.pop_front();
               check_field("status", 32'(expd.status), 32'(rsp_status));
               check_field("was_new", 32'(expd.was_new), 32'(rsp_was_new));
               check_field("entry_index", 32'(expd.index), 32'(rsp_entry_index));
               check_field("entry_colour", expd.colour, rsp_entry_colour);
               check_field("entry_count", 32'(expd.count), 32'(rsp_entry_count));
               check_field("entries_used", 32'(expd.used), 32'(rsp_entries_used));
            end
         end
         if (req_valid && !req_stall) begin
            expd = predict_histogram(cht_pkg::kind_type'(req_kind), req_argb, req_row_start,
                                     req_read_index);
            if (typed_valid)
               expd = typed_result;
            pending_results = {pending_results, expd};
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99, 0) < stall_pct);
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("no progress for %0d cycles", STUCK_LIMIT);
      $display("FAIL colour_histogram_table");
      $finish;
   end

   function automatic void add_step(bit cfg_en, int cfg_val, cht_pkg::kind_type kind,
                                    logic [31:0] argb, logic row_start, int rd_idx,
                                    bit typed, lookup_type res);
      step_type s;
      s.cfg_en    = cfg_en;
      s.cfg_val   = USED_W'(cfg_val);
      s.kind      = kind;
      s.argb      = argb;
      s.row_start = row_start;
      s.rd_idx    = IDX_W'(rd_idx);
      s.typed     = typed;
      s.res       = res;
      directed_steps = {directed_steps, s};
   endfunction

   // called just after a falling edge; leaves valid high once accepted
   task automatic send_request(cht_pkg::kind_type kind, logic [31:0] argb, logic row_start,
                               logic [IDX_W-1:0] rd_idx);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_kind       = kind;
      req_argb       = argb;
      req_row_start  = row_start;
      req_read_index = rd_idx;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic send_random();
      int unsigned       pick;
      cht_pkg::kind_type kind;
      logic [31:0]       colour;
      logic [IDX_W-1:0]  rd_idx;
      pick = $urandom_range(99, 0);
      if (pick < 76)
         kind = cht_pkg::KIND_PIXEL;
      else if (pick < 90)
         kind = cht_pkg::KIND_READ;
      else if (pick < 95)
         kind = cht_pkg::KIND_CLEAR;
      else
         kind = cht_pkg::KIND_NONE;
      // mostly repeat colours so hits and limits get exercised
      if ($urandom_range(99, 0) < 85)
         colour = palette[$urandom_range(PALETTE_N - 1, 0)];
      else
         colour = $urandom();
      if ($urandom_range(99, 0) < 70)
         rd_idx = IDX_W'($urandom_range(15, 0));
      else
         rd_idx = IDX_W'($urandom_range(DEPTH - 1, 0));
      send_request(kind, colour, $urandom_range(99, 0) < 15, rd_idx);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(logic [USED_W-1:0] value);
      csr_wen   = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_wen   = 1'b0;
   endtask

   initial begin
      logic [31:0]      colour;
      logic [31:0]      fill_colours [DEPTH];
      logic [IDX_W-1:0] rd_idx;
      int               lim;
      int               phase_limit [N_PHASES] = '{DEPTH, 0, 3, DEPTH - 1, 1, 8, 12, -1};
      int               phase_items [N_PHASES] = '{70, 60, 70, 60, 60, 70, 70, 70};
      int               phase_send_idle [N_PHASES] = '{0, 52, 0, 21, 0, 52, 0, 21};
      int               phase_stall [N_PHASES] = '{0, 0, 52, 21, 0, 0, 52, 21};

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = cht_pkg::KIND_PIXEL;
      req_argb       = '0;
      req_row_start  = 1'b0;
      req_read_index = '0;
      csr_wen        = 1'b0;
      csr_wdata      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fields of the typed result: status, was_new, index, colour, count, used
      add_step(0, 0, cht_pkg::KIND_READ, 32'h0, 0, 0, 1,
               {1'b0, 1'b0, 8'd0, 32'h0, 24'd0, 9'd0});
      add_step(0, 0, cht_pkg::KIND_READ, 32'hFFFFFFFF, 1, 255, 1,
               {1'b0, 1'b0, 8'd255, 32'h0, 24'd0, 9'd0});
      add_step(0, 0, cht_pkg::KIND_NONE, 32'hFFFFFFFF, 1, 255, 1,
               {1'b0, 1'b0, 8'd0, 32'h0, 24'd0, 9'd0});
      add_step(0, 0, cht_pkg::KIND_PIXEL, 32'h0, 1, 0, 1,
               {1'b0, 1'b1, 8'd0, 32'h0, 24'd1, 9'd1});
      add_step(0, 0, cht_pkg::KIND_PIXEL, 32'hFFFFFFFF, 0, 0, 1,
               {1'b0, 1'b1, 8'd1, 32'hFFFFFFFF, 24'd1, 9'd2});
      add_step(0, 0, cht_pkg::KIND_PIXEL, 32'h0, 0, 0, 1,
               {1'b0, 1'b0, 8'd0, 32'h0, 24'd2, 9'd2});
      add_step(0, 0, cht_pkg::KIND_PIXEL, 32'hA5A5A5A5, 0, 0, 1,
               {1'b0, 1'b1, 8'd2, 32'hA5A5A5A5, 24'd1, 9'd3});
      add_step(0, 0, cht_pkg::KIND_PIXEL, 32'hFFFFFFFF, 1, 0, 0, '0);
      add_step(0, 0, cht_pkg::KIND_READ, 32'h0, 0, 1, 0, '0);
      add_step(0, 0, cht_pkg::KIND_READ, 32'h0, 0, 3, 1,
               {1'b0, 1'b0, 8'd3, 32'h0, 24'd0, 9'd3});
      add_step(0, 0, cht_pkg::KIND_NONE, 32'hFFFFFFFF, 1, 255, 1,
               {1'b0, 1'b0, 8'd0, 32'h0, 24'd0, 9'd3});
      // limit 2 with four entries: next row start trips the failure
      add_step(1, 2, cht_pkg::KIND_PIXEL, 32'h5A5A5A5A, 0, 0, 0, '0);
      add_step(0, 0, cht_pkg::KIND_PIXEL, 32'h0, 1, 0, 1,
               {1'b1, 1'b0, 8'd0, 32'h0, 24'd0, 9'd4});
      add_step(0, 0, cht_pkg::KIND_PIXEL, 32'h12345678, 0, 0, 1,
               {1'b1, 1'b0, 8'd0, 32'h0, 24'd0, 9'd4});
      add_step(0, 0, cht_pkg::KIND_READ, 32'h0, 0, 0, 0, '0);
      add_step(0, 0, cht_pkg::KIND_READ, 32'h0, 0, 200, 1,
               {1'b1, 1'b0, 8'd200, 32'h0, 24'd0, 9'd4});
      add_step(0, 0, cht_pkg::KIND_NONE, 32'h0, 0, 0, 1,
               {1'b1, 1'b0, 8'd0, 32'h0, 24'd0, 9'd4});
      add_step(0, 0, cht_pkg::KIND_CLEAR, 32'hFFFFFFFF, 1, 255, 1,
               {1'b0, 1'b0, 8'd0, 32'h0, 24'd0, 9'd0});
      add_step(0, 0, cht_pkg::KIND_READ, 32'h0, 0, 0, 1,
               {1'b0, 1'b0, 8'd0, 32'h0, 24'd0, 9'd0});
      add_step(1, 0, cht_pkg::KIND_PIXEL, 32'h80000001, 1, 0, 0, '0);
      add_step(0, 0, cht_pkg::KIND_PIXEL, 32'h80000001, 1, 0, 1,
               {1'b1, 1'b0, 8'd0, 32'h0, 24'd0, 9'd1});
      add_step(0, 0, cht_pkg::KIND_CLEAR, 32'h0, 0, 0, 1,
               {1'b0, 1'b0, 8'd0, 32'h0, 24'd0, 9'd0});
      add_step(0, 0, cht_pkg::KIND_PIXEL, 32'h7FFFFFFF, 0, 0, 0, '0);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].cfg_en) begin
            wait_idle();
            write_limit(directed_steps[i].cfg_val);
         end
         typed_valid  = directed_steps[i].typed;
         typed_result = directed_steps[i].res;
         send_request(directed_steps[i].kind, directed_steps[i].argb,
                      directed_steps[i].row_start, directed_steps[i].rd_idx);
      end
      typed_valid = 1'b0;

      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         send_idle_pct = phase_send_idle[p];
         stall_pct     = phase_stall[p];
         lim = (phase_limit[p] < 0) ? $urandom_range(DEPTH, 0) : phase_limit[p];
         write_limit(USED_W'(lim));
         for (int c = 0; c < PALETTE_N; c++)
            palette[c] = $urandom();
         repeat (phase_items[p]) send_random();
      end

      // fill every entry, then hit, read and overflow the full table
      wait_idle();
      send_idle_pct = 21;
      stall_pct     = 52;
      write_limit(USED_W'(DEPTH));
      send_request(cht_pkg::KIND_CLEAR, $urandom(), 1'b1, 8'hFF);
      for (int i = 0; i < DEPTH; i++) begin
         colour          = $urandom();
         colour[7:0]     = 8'(i);
         fill_colours[i] = colour;
         send_request(cht_pkg::KIND_PIXEL, colour, (i % 32) == 0,
                      IDX_W'($urandom_range(DEPTH - 1, 0)));
      end
      for (int k = 0; k < 28; k++) begin
         // overflow after 20 requests; the rest see the failure
         if (k == 20) begin
            send_request(cht_pkg::KIND_PIXEL, $urandom(), 1'b0, '0);
         end else begin
            rd_idx = ($urandom_range(3, 0) == 0) ? IDX_W'(DEPTH - 1)
                                                 : IDX_W'($urandom_range(DEPTH - 1, 0));
            if ($urandom_range(1, 0) == 1)
               send_request(cht_pkg::KIND_PIXEL, fill_colours[rd_idx],
                            1'($urandom_range(1, 0)), rd_idx);
            else
               send_request(cht_pkg::KIND_READ, $urandom(), 1'($urandom_range(1, 0)),
                            rd_idx);
         end
      end
      send_request(cht_pkg::KIND_CLEAR, $urandom(), 1'b0, '0);

      req_valid = 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (DEPTH + 8) @(negedge clock);

      $display("%0d requests sent, %0d responses checked, %0d mismatches",
               sent_count, result_count, mismatch_count);
      $display("covered: directed corners, %0d random limit settings, full table overflow",
               N_PHASES);
      if (mismatch_count == 0)
         $display("PASS colour_histogram_table");
      else
         $display("FAIL colour_histogram_table");
      $finish;
   end

endmodule
